### hw/rtl/isbs_pkg.sv
// ============================================================================
// isbs_pkg
// Shared constants for the implicit saturation bisection solver.
// ============================================================================
`default_nettype none

package isbs_pkg;

    localparam int ITERATIONS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 30;

    // port field widths
    localparam int FLUX_W  = 31;
    localparam int BETA_W  = 32;
    localparam int MOB_W   = 32;
    localparam int NEWS_W  = 32;
    localparam int ROOT_W  = 31;

    // beta and M are Q8.24
    localparam int MOB_FRAC = 24;

    // wide quotients saturate at 2^62
    localparam int WIDE_W   = 63;
    localparam int CAP_BIT  = 62;

    // configuration port
    localparam int  APB_AW       = 3;
    localparam int  APB_DW       = 32;
    localparam logic REG_MOBILITY = 1'b0;
    localparam logic [MOB_W-1:0] MOB_RESET = 32'h0100_0000;

endpackage

`default_nettype wire

### hw/rtl/isbs_div.sv
// ============================================================================
// isbs_div
// Pipelined restoring divider, one quotient bit per stage:
// quo = min(floor(num * 2^SH / den), cap) with cap = 2^CAPB, or all ones when
// CAPB >= QW; den == 0 gives cap (or 0 for a zero numerator).
// ============================================================================
`default_nettype none

module isbs_div #(
    parameter int NW   = 8,
    parameter int SH   = 8,
    parameter int DW   = 8,
    parameter int QW   = 8,
    parameter int CAPB = 62,
    parameter int TW   = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [TW-1:0] i_tag,
    output logic               o_valid,
    output logic [QW-1:0]      o_quo,
    output logic [TW-1:0]      o_tag
);

    localparam int EW = NW + SH + DW + QW + 1;
    localparam logic [QW-1:0] CAPV = (CAPB < QW) ? (QW'(1) << CAPB) : '1;

    logic [EW-1:0] num_x;
    logic [EW-1:0] top;
    logic          ovf_in;

    // quotient overflows QW bits exactly when the leading part reaches den
    assign num_x  = EW'(i_num) << SH;
    assign top    = num_x >> QW;
    assign ovf_in = top >= EW'(i_den);

    logic          r_v    [0:QW];
    logic [DW-1:0] r_rem  [0:QW];
    logic [QW-1:0] r_nq   [0:QW];
    logic [DW-1:0] r_den  [0:QW];
    logic          r_sat  [0:QW];
    logic          r_zero [0:QW];
    logic [TW-1:0] r_tag  [0:QW];

    logic [DW:0] trial [0:QW-1];
    logic [DW:0] sub   [0:QW-1];
    logic        ge    [0:QW-1];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            trial[k] = {r_rem[k], r_nq[k][QW-1]};
            sub[k]   = trial[k] - {1'b0, r_den[k]};
            ge[k]    = trial[k] >= {1'b0, r_den[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int k = 0; k < QW; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= top[DW-1:0];
        r_nq[0]   <= num_x[QW-1:0];
        r_den[0]  <= i_den;
        r_sat[0]  <= (i_den == '0) ? (i_num != '0) : ovf_in;
        r_zero[0] <= (i_den == '0) && (i_num == '0);
        r_tag[0]  <= i_tag;
        for (int k = 0; k < QW; k++) begin
            r_rem[k+1]  <= ge[k] ? sub[k][DW-1:0] : trial[k][DW-1:0];
            r_nq[k+1]   <= {r_nq[k][QW-2:0], ge[k]};
            r_den[k+1]  <= r_den[k];
            r_sat[k+1]  <= r_sat[k];
            r_zero[k+1] <= r_zero[k];
            r_tag[k+1]  <= r_tag[k];
        end
    end

    always_comb begin
        if (r_zero[QW]) begin
            o_quo = '0;
        end else if (r_sat[QW] || (r_nq[QW] > CAPV)) begin
            o_quo = CAPV;
        end else begin
            o_quo = r_nq[QW];
        end
    end

    assign o_valid = r_v[QW];
    assign o_tag   = r_tag[QW];

endmodule

`default_nettype wire

### hw/rtl/isbs_resid.sv
// ============================================================================
// isbs_resid
// Residual pipeline: R(u) = u - u_old + beta*(f(u) - a) with
// f(u) = u^2 / (u^2 + M*(1-u)^2). Also returns the flow denominator.
// ============================================================================
`default_nettype none

module isbs_resid #(
    parameter int F  = 30,
    parameter int TW = 1,
    localparam int XW = (F + 1 > isbs_pkg::FLUX_W) ? F + 1 : isbs_pkg::FLUX_W,
    localparam int DW = F + 10,
    localparam int RW = XW + 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic [F:0]                        i_u,
    input  wire logic [isbs_pkg::FLUX_W-1:0]       i_a,
    input  wire logic [isbs_pkg::BETA_W-1:0]       i_beta,
    input  wire logic [isbs_pkg::FLUX_W-1:0]       i_uold,
    input  wire logic [isbs_pkg::MOB_W-1:0]        i_m,
    input  wire logic [TW-1:0]                     i_tag,
    output logic                                   o_valid,
    output logic [F:0]                             o_u,
    output logic [isbs_pkg::FLUX_W-1:0]            o_a,
    output logic [isbs_pkg::BETA_W-1:0]            o_beta,
    output logic [isbs_pkg::FLUX_W-1:0]            o_uold,
    output logic signed [RW-1:0]                   o_r,
    output logic [DW-1:0]                          o_d,
    output logic [TW-1:0]                          o_tag
);

    localparam int AW = isbs_pkg::FLUX_W;
    localparam int BW = isbs_pkg::BETA_W;
    localparam int MF = isbs_pkg::MOB_FRAC;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
    localparam int PT = (F + 1) + AW + BW + AW + DW + TW;

    // ---- P1: squares ----
    logic [2*F+1:0] puu, pww;
    logic [F:0]     w_in;
    assign w_in = ONE - i_u;
    assign puu  = i_u * i_u;
    assign pww  = w_in * w_in;

    logic          r1_v;
    logic [F:0]    r1_u, r1_u2, r1_w2;
    logic [AW-1:0] r1_a, r1_o;
    logic [BW-1:0] r1_b;
    logic [TW-1:0] r1_tag;

    // ---- P2: M * (1-u)^2 ----
    logic [F+32:0] pmw;
    assign pmw = i_m * r1_w2;

    logic          r2_v;
    logic [F:0]    r2_u, r2_u2;
    logic [F+8:0]  r2_mw2;
    logic [AW-1:0] r2_a, r2_o;
    logic [BW-1:0] r2_b;
    logic [TW-1:0] r2_tag;

    // ---- P3: denominator ----
    logic          r3_v;
    logic [F:0]    r3_u, r3_u2;
    logic [DW-1:0] r3_d;
    logic [AW-1:0] r3_a, r3_o;
    logic [BW-1:0] r3_b;
    logic [TW-1:0] r3_tag;

    // ---- flow quotient ----
    logic          dv_v;
    logic [F:0]    dv_f;
    logic [PT-1:0] dv_tag;
    logic [F:0]    dv_u;
    logic [AW-1:0] dv_a, dv_o;
    logic [BW-1:0] dv_b;
    logic [DW-1:0] dv_d;
    logic [TW-1:0] dv_t;

    isbs_div #(
        .NW(F + 1), .SH(F), .DW(DW), .QW(F + 1), .CAPB(F), .TW(PT)
    ) u_flow_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_v),
        .i_num   (r3_u2),
        .i_den   (r3_d),
        .i_tag   ({r3_u, r3_a, r3_b, r3_o, r3_d, r3_tag}),
        .o_valid (dv_v),
        .o_quo   (dv_f),
        .o_tag   (dv_tag)
    );

    assign {dv_u, dv_a, dv_b, dv_o, dv_d, dv_t} = dv_tag;

    // ---- P4: f - a and u - u_old ----
    logic [XW:0]   dif;
    logic [XW-1:0] mag_c;
    assign dif   = (XW+1)'(dv_f) - (XW+1)'(dv_a);
    assign mag_c = dif[XW] ? (~dif[XW-1:0] + 1'b1) : dif[XW-1:0];

    logic                r4_v, r4_neg;
    logic [XW-1:0]       r4_mag;
    logic signed [XW:0]  r4_base;
    logic [F:0]          r4_u;
    logic [AW-1:0]       r4_a, r4_o;
    logic [BW-1:0]       r4_b;
    logic [DW-1:0]       r4_d;
    logic [TW-1:0]       r4_tag;

    // ---- P5: beta * |f - a| ----
    logic [XW+31:0] pbt;
    assign pbt = r4_b * r4_mag;

    logic                r5_v, r5_neg;
    logic [XW+7:0]       r5_bt;
    logic signed [XW:0]  r5_base;
    logic [F:0]          r5_u;
    logic [AW-1:0]       r5_a, r5_o;
    logic [BW-1:0]       r5_b;
    logic [DW-1:0]       r5_d;
    logic [TW-1:0]       r5_tag;

    // ---- P6: residual ----
    logic signed [RW-1:0] base_x, bt_x, r_c;
    assign base_x = RW'(r5_base);
    assign bt_x   = RW'(r5_bt);
    assign r_c    = r5_neg ? (base_x - bt_x) : (base_x + bt_x);

    logic                 r6_v;
    logic signed [RW-1:0] r6_r;
    logic [F:0]           r6_u;
    logic [AW-1:0]        r6_a, r6_o;
    logic [BW-1:0]        r6_b;
    logic [DW-1:0]        r6_d;
    logic [TW-1:0]        r6_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= dv_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_u   <= i_u;
        r1_u2  <= puu[2*F:F];
        r1_w2  <= pww[2*F:F];
        r1_a   <= i_a;
        r1_b   <= i_beta;
        r1_o   <= i_uold;
        r1_tag <= i_tag;

        r2_u   <= r1_u;
        r2_u2  <= r1_u2;
        r2_mw2 <= pmw[F+32:MF];
        r2_a   <= r1_a;
        r2_b   <= r1_b;
        r2_o   <= r1_o;
        r2_tag <= r1_tag;

        r3_u   <= r2_u;
        r3_u2  <= r2_u2;
        r3_d   <= DW'(r2_u2) + DW'(r2_mw2);
        r3_a   <= r2_a;
        r3_b   <= r2_b;
        r3_o   <= r2_o;
        r3_tag <= r2_tag;

        r4_neg  <= dif[XW];
        r4_mag  <= mag_c;
        r4_base <= (XW+1)'(dv_u) - (XW+1)'(dv_o);
        r4_u    <= dv_u;
        r4_a    <= dv_a;
        r4_b    <= dv_b;
        r4_o    <= dv_o;
        r4_d    <= dv_d;
        r4_tag  <= dv_t;

        r5_neg  <= r4_neg;
        r5_bt   <= pbt[XW+31:MF];
        r5_base <= r4_base;
        r5_u    <= r4_u;
        r5_a    <= r4_a;
        r5_b    <= r4_b;
        r5_o    <= r4_o;
        r5_d    <= r4_d;
        r5_tag  <= r4_tag;

        r6_r    <= r_c;
        r6_u    <= r5_u;
        r6_a    <= r5_a;
        r6_b    <= r5_b;
        r6_o    <= r5_o;
        r6_d    <= r5_d;
        r6_tag  <= r5_tag;
    end

    assign o_valid = r6_v;
    assign o_u     = r6_u;
    assign o_a     = r6_a;
    assign o_beta  = r6_b;
    assign o_uold  = r6_o;
    assign o_r     = r6_r;
    assign o_d     = r6_d;
    assign o_tag   = r6_tag;

endmodule

`default_nettype wire

### hw/rtl/isbs_newton.sv
// ============================================================================
// isbs_newton
// One Newton correction at the bisection root: residual, analytic slope,
// step quotient and saturation to 32-bit signed.
// ============================================================================
`default_nettype none

module isbs_newton #(
    parameter int F = 30
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic [F:0]                        i_root,
    input  wire logic [isbs_pkg::FLUX_W-1:0]       i_a,
    input  wire logic [isbs_pkg::BETA_W-1:0]       i_beta,
    input  wire logic [isbs_pkg::FLUX_W-1:0]       i_uold,
    input  wire logic [isbs_pkg::MOB_W-1:0]        i_m,
    output logic                                   o_valid,
    output logic signed [isbs_pkg::NEWS_W-1:0]     o_new,
    output logic [isbs_pkg::ROOT_W-1:0]            o_root
);

    localparam int AW = isbs_pkg::FLUX_W;
    localparam int BW = isbs_pkg::BETA_W;
    localparam int MF = isbs_pkg::MOB_FRAC;
    localparam int GW = isbs_pkg::WIDE_W;
    localparam int XW = (F + 1 > AW) ? F + 1 : AW;
    localparam int DW = F + 10;
    localparam int RW = XW + 10;
    localparam int CW = RW + 2;
    localparam int NWD = isbs_pkg::NEWS_W;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
    localparam logic [GW-1:0] ONE_G = GW'(ONE);
    localparam logic [GW-1:0] CAP_G = GW'(1) << isbs_pkg::CAP_BIT;
    localparam logic signed [CW-1:0] SMAX = CW'({(NWD-1){1'b1}});
    localparam logic signed [CW-1:0] SMIN = -SMAX - CW'(1);

    // ---- N0: u*(1-u) ----
    logic [2*F+1:0] ppw;
    assign ppw = i_root * (ONE - i_root);

    logic          r0_v;
    logic [F:0]    r0_root;
    logic [F-2:0]  r0_p;
    logic [AW-1:0] r0_a, r0_o;
    logic [BW-1:0] r0_b;

    // ---- residual at the root ----
    logic                 rs_v;
    logic [F:0]           rs_u;
    logic [BW-1:0]        rs_b;
    logic signed [RW-1:0] rs_r;
    logic [DW-1:0]        rs_d;
    logic [F-2:0]         rs_p;

    isbs_resid #(.F(F), .TW(F - 1)) u_resid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_v),
        .i_u     (r0_root),
        .i_a     (r0_a),
        .i_beta  (r0_b),
        .i_uold  (r0_o),
        .i_m     (i_m),
        .i_tag   (r0_p),
        .o_valid (rs_v),
        .o_u     (rs_u),
        .o_a     (),
        .o_beta  (rs_b),
        .o_uold  (),
        .o_r     (rs_r),
        .o_d     (rs_d),
        .o_tag   (rs_p)
    );

    // ---- N1: 2*M*u*(1-u) ----
    logic [F+30:0] pmn;
    assign pmn = i_m * rs_p;

    logic                 r1_v;
    logic [F+7:0]         r1_n;
    logic signed [RW-1:0] r1_r;
    logic [DW-1:0]        r1_d;
    logic [F:0]           r1_u;
    logic [BW-1:0]        r1_b;

    // ---- two divisions by the denominator ----
    localparam int T1 = RW + DW + (F + 1) + BW;
    localparam int T2 = RW + (F + 1) + BW;

    logic          g1_v;
    logic [GW-1:0] g1_q;
    logic [T1-1:0] g1_tag;
    logic signed [RW-1:0] g1_r;
    logic [DW-1:0] g1_d;
    logic [F:0]    g1_u;
    logic [BW-1:0] g1_b;

    isbs_div #(
        .NW(F + 8), .SH(F), .DW(DW), .QW(GW), .CAPB(isbs_pkg::CAP_BIT), .TW(T1)
    ) u_g1_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_v),
        .i_num   (r1_n),
        .i_den   (r1_d),
        .i_tag   ({r1_r, r1_d, r1_u, r1_b}),
        .o_valid (g1_v),
        .o_quo   (g1_q),
        .o_tag   (g1_tag)
    );

    assign {g1_r, g1_d, g1_u, g1_b} = g1_tag;

    logic          g2_v;
    logic [GW-1:0] g2_q;
    logic [T2-1:0] g2_tag;
    logic signed [RW-1:0] g2_r;
    logic [F:0]    g2_u;
    logic [BW-1:0] g2_b;

    isbs_div #(
        .NW(GW), .SH(F), .DW(DW), .QW(GW), .CAPB(isbs_pkg::CAP_BIT), .TW(T2)
    ) u_g2_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (g1_v),
        .i_num   (g1_q),
        .i_den   (g1_d),
        .i_tag   ({g1_r, g1_u, g1_b}),
        .o_valid (g2_v),
        .o_quo   (g2_q),
        .o_tag   (g2_tag)
    );

    assign {g2_r, g2_u, g2_b} = g2_tag;

    // ---- N2..N4: slope = one + min(beta*g >> 24, 2^62) ----
    logic [2*BW-1:0] plo;
    assign plo = g2_b * g2_q[BW-1:0];

    logic                 r2_v;
    logic [2*BW-1:0]      r2_plo;
    logic [GW-BW-1:0]     r2_ghi;
    logic [BW-1:0]        r2_b;
    logic signed [RW-1:0] r2_r;
    logic [F:0]           r2_u;

    logic [GW-1:0]      mhi;
    logic [GW+BW-1:0]   prod_c;
    assign mhi    = r2_b * r2_ghi;
    assign prod_c = {mhi, {BW{1'b0}}} + (GW+BW)'(r2_plo);

    logic                 r3_v;
    logic [GW+BW-1:0]     r3_prod;
    logic signed [RW-1:0] r3_r;
    logic [F:0]           r3_u;

    logic [GW+BW-MF-1:0] btp;
    logic [GW-1:0]       btc;
    logic [RW-1:0]       mag_c;
    assign btp   = r3_prod[GW+BW-1:MF];
    assign btc   = (btp > (GW+BW-MF)'(CAP_G)) ? CAP_G : btp[GW-1:0];
    assign mag_c = r3_r[RW-1] ? (~r3_r + 1'b1) : r3_r;

    logic          r4_v, r4_neg;
    logic [GW-1:0] r4_slope;
    logic [RW-1:0] r4_mag;
    logic [F:0]    r4_u;

    // ---- step = |R| / slope ----
    logic             st_v;
    logic [RW-1:0]    st_q;
    logic [F+1:0]     st_tag;
    logic             st_neg;
    logic [F:0]       st_u;

    isbs_div #(
        .NW(RW), .SH(F), .DW(GW), .QW(RW), .CAPB(isbs_pkg::CAP_BIT), .TW(F + 2)
    ) u_step_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_v),
        .i_num   (r4_mag),
        .i_den   (r4_slope),
        .i_tag   ({r4_neg, r4_u}),
        .o_valid (st_v),
        .o_quo   (st_q),
        .o_tag   (st_tag)
    );

    assign {st_neg, st_u} = st_tag;

    // ---- N5: correction and clamp ----
    logic signed [CW-1:0] cu, cs, corr;
    logic signed [NWD-1:0] clamp_c;
    assign cu   = CW'(st_u);
    assign cs   = CW'(st_q);
    assign corr = st_neg ? (cu + cs) : (cu - cs);

    always_comb begin
        if (corr > SMAX) begin
            clamp_c = SMAX[NWD-1:0];
        end else if (corr < SMIN) begin
            clamp_c = SMIN[NWD-1:0];
        end else begin
            clamp_c = corr[NWD-1:0];
        end
    end

    logic                  r5_v;
    logic signed [NWD-1:0] r5_new;
    logic [isbs_pkg::ROOT_W-1:0] r5_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            r0_v <= i_valid;
            r1_v <= rs_v;
            r2_v <= g2_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= st_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_root <= i_root;
        r0_p    <= ppw[2*F-2:F];
        r0_a    <= i_a;
        r0_b    <= i_beta;
        r0_o    <= i_uold;

        r1_n    <= {pmn[F+30:MF], 1'b0};
        r1_r    <= rs_r;
        r1_d    <= rs_d;
        r1_u    <= rs_u;
        r1_b    <= rs_b;

        r2_plo  <= plo;
        r2_ghi  <= g2_q[GW-1:BW];
        r2_b    <= g2_b;
        r2_r    <= g2_r;
        r2_u    <= g2_u;

        r3_prod <= prod_c;
        r3_r    <= r2_r;
        r3_u    <= r2_u;

        r4_slope <= btc + ONE_G;
        r4_neg   <= r3_r[RW-1];
        r4_mag   <= mag_c;
        r4_u     <= r3_u;

        r5_new  <= clamp_c;
        r5_root <= isbs_pkg::ROOT_W'(st_u);
    end

    assign o_valid = r5_v;
    assign o_new   = r5_new;
    assign o_root  = r5_root;

endmodule

`default_nettype wire

### hw/rtl/implicit_saturation_bisection_solver.sv
// Path from start to o_done: the input register, each bisection step (a residual
//   pipeline with its flow divider), then the Newton correction.
// Throughput: one transaction per cycle; busy is never raised.
// Results come out on o_done for one cycle; the receiver cannot stall them.
// Reset (synchronous, active low) drops every item in flight and sets
//   the mobility register to 1.0.
// ============================================================================
// implicit_saturation_bisection_solver
// Fully pipelined implicit saturation solver: unrolled bisection stages on
// the residual, then one Newton correction with the analytic slope.
// ============================================================================
`default_nettype none

module implicit_saturation_bisection_solver #(
    parameter int ITERATIONS    = isbs_pkg::ITERATIONS_DEF,
    parameter int FRACTION_BITS = isbs_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [isbs_pkg::FLUX_W-1:0]        i_flux_target,
    input  wire logic [isbs_pkg::BETA_W-1:0]        i_step_ratio,
    input  wire logic [isbs_pkg::FLUX_W-1:0]        i_old_saturation,
    output logic                                    o_done,
    output logic signed [isbs_pkg::NEWS_W-1:0]      o_new_saturation,
    output logic [isbs_pkg::ROOT_W-1:0]             o_bisection_root,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [isbs_pkg::APB_AW-1:0]        paddr,
    input  wire logic [isbs_pkg::APB_DW-1:0]        pwdata,
    output logic [isbs_pkg::APB_DW-1:0]             prdata,
    output logic                                    pready
);

    localparam int F  = FRACTION_BITS;
    localparam int AW = isbs_pkg::FLUX_W;
    localparam int BW = isbs_pkg::BETA_W;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    // ---- configuration ----
    logic [isbs_pkg::MOB_W-1:0] r_mobility;
    logic                       reg_hit;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign reg_hit = paddr[2] == isbs_pkg::REG_MOBILITY;
    assign prdata  = reg_hit ? r_mobility : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mobility <= isbs_pkg::MOB_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_mobility <= pwdata;
        end
    end

    // ---- input register ----
    logic          r_in_v;
    logic [AW-1:0] r_in_a, r_in_o;
    logic [BW-1:0] r_in_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_a <= i_flux_target;
        r_in_b <= i_step_ratio;
        r_in_o <= i_old_saturation;
    end

    // ---- bracket chain ----
    logic          bv  [0:ITERATIONS];
    logic [F:0]    blo [0:ITERATIONS];
    logic [F:0]    bhi [0:ITERATIONS];
    logic [AW-1:0] ba  [0:ITERATIONS];
    logic [BW-1:0] bb  [0:ITERATIONS];
    logic [AW-1:0] bo  [0:ITERATIONS];

    assign bv[0]  = r_in_v;
    assign blo[0] = '0;
    assign bhi[0] = ONE;
    assign ba[0]  = r_in_a;
    assign bb[0]  = r_in_b;
    assign bo[0]  = r_in_o;

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_step
        localparam int XW = (F + 1 > AW) ? F + 1 : AW;
        localparam int RW = XW + 10;

        logic [F+1:0]         sum;
        logic [F:0]           mid;
        logic                 rs_v;
        logic [F:0]           rs_u;
        logic [AW-1:0]        rs_a, rs_o;
        logic [BW-1:0]        rs_b;
        logic signed [RW-1:0] rs_r;
        logic [2*F+1:0]       rs_tag;
        logic [F:0]           rs_lo, rs_hi;

        logic          r_v;
        logic [F:0]    r_lo, r_hi;
        logic [AW-1:0] r_a, r_o;
        logic [BW-1:0] r_b;

        assign sum = (F+2)'(blo[k]) + (F+2)'(bhi[k]);
        assign mid = sum[F+1:1];

        isbs_resid #(.F(F), .TW(2 * F + 2)) u_resid (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (bv[k]),
            .i_u     (mid),
            .i_a     (ba[k]),
            .i_beta  (bb[k]),
            .i_uold  (bo[k]),
            .i_m     (r_mobility),
            .i_tag   ({blo[k], bhi[k]}),
            .o_valid (rs_v),
            .o_u     (rs_u),
            .o_a     (rs_a),
            .o_beta  (rs_b),
            .o_uold  (rs_o),
            .o_r     (rs_r),
            .o_d     (),
            .o_tag   (rs_tag)
        );

        assign {rs_lo, rs_hi} = rs_tag;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= rs_v;
            end
        end

        // an exactly zero residual keeps the bracket
        always_ff @(posedge i_clk) begin
            r_lo <= (rs_r < 0) ? rs_u : rs_lo;
            r_hi <= (rs_r > 0) ? rs_u : rs_hi;
            r_a  <= rs_a;
            r_b  <= rs_b;
            r_o  <= rs_o;
        end

        assign bv[k+1]  = r_v;
        assign blo[k+1] = r_lo;
        assign bhi[k+1] = r_hi;
        assign ba[k+1]  = r_a;
        assign bb[k+1]  = r_b;
        assign bo[k+1]  = r_o;
    end

    // ---- final midpoint and Newton correction ----
    logic [F+1:0] root_sum;
    logic [F:0]   root;
    assign root_sum = (F+2)'(blo[ITERATIONS]) + (F+2)'(bhi[ITERATIONS]);
    assign root     = root_sum[F+1:1];

    isbs_newton #(.F(F)) u_newton (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (bv[ITERATIONS]),
        .i_root  (root),
        .i_a     (ba[ITERATIONS]),
        .i_beta  (bb[ITERATIONS]),
        .i_uold  (bo[ITERATIONS]),
        .i_m     (r_mobility),
        .o_valid (o_done),
        .o_new   (o_new_saturation),
        .o_root  (o_bisection_root)
    );

endmodule

`default_nettype wire

### hw/rtl/isbs_checker.sv
// ============================================================================
// isbs_checker
// Port-level checks for the solver, bound to the top level.
// ============================================================================
`default_nettype none

module isbs_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          busy,
    input wire logic                          o_done,
    input wire logic [isbs_pkg::ROOT_W-1:0]   o_bisection_root,
    input wire logic                          psel,
    input wire logic                          penable,
    input wire logic                          pwrite,
    input wire logic [isbs_pkg::APB_AW-1:0]   paddr,
    input wire logic [isbs_pkg::APB_DW-1:0]   pwdata,
    input wire logic [isbs_pkg::APB_DW-1:0]   prdata,
    input wire logic                          pready
);

    // pipeline flushed by reset: nothing comes out right after it
    a_no_done_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    a_root_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_bisection_root <= 31'h4000_0000))
        else $error("bisection root above one");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // register read-back after a write transaction
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && !paddr[2])
        |=> (paddr[2] || (prdata == $past(pwdata))))
        else $error("mobility register read-back mismatch");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind implicit_saturation_bisection_solver isbs_checker u_isbs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .busy             (busy),
    .o_done           (o_done),
    .o_bisection_root (o_bisection_root),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
);

`default_nettype wire

### bench/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the implicit saturation bisection solver: directed
// and random cells under several mobility ratios and idle patterns, checked
// against an in-bench fixed-point predictor of bisection plus Newton polish.
// ============================================================================
`timescale 1ns / 100ps

module tb_top;

    localparam int  FB      = isbs_pkg::FRACTION_BITS_DEF;
    localparam int  NITER   = isbs_pkg::ITERATIONS_DEF;
    localparam int  LATENCY = 1463;
    localparam longint LIMIT = 64'd2_000_000;
    localparam logic [63:0] ONE_FX  = 64'd1 << FB;
    localparam logic [63:0] BIG_CAP = 64'd1 << isbs_pkg::CAP_BIT;

    typedef struct packed {
        logic [isbs_pkg::FLUX_W-1:0] flux;
        logic [isbs_pkg::BETA_W-1:0] beta;
        logic [isbs_pkg::FLUX_W-1:0] sat_old;
    } t_cell;

    typedef struct packed {
        logic signed [isbs_pkg::NEWS_W-1:0] new_sat;
        logic [isbs_pkg::ROOT_W-1:0]        root;
    } t_sol;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [isbs_pkg::FLUX_W-1:0] i_flux_target = '0;
    logic [isbs_pkg::BETA_W-1:0] i_step_ratio = '0;
    logic [isbs_pkg::FLUX_W-1:0] i_old_saturation = '0;
    logic o_done;
    logic signed [isbs_pkg::NEWS_W-1:0] o_new_saturation;
    logic [isbs_pkg::ROOT_W-1:0] o_bisection_root;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [isbs_pkg::APB_AW-1:0] paddr = '0;
    logic [isbs_pkg::APB_DW-1:0] pwdata = '0;
    logic [isbs_pkg::APB_DW-1:0] prdata;
    logic pready;

    implicit_saturation_bisection_solver uut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_flux_target, .i_step_ratio, .i_old_saturation,
        .o_done, .o_new_saturation, .o_bisection_root,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_cell  cell_q[$];
    t_sol   solution_q[$];
    logic [isbs_pkg::MOB_W-1:0] mob_ratio = isbs_pkg::MOB_RESET;
    int     idle_pct = 0;
    int     errors = 0;
    int     cells_sent = 0;
    int     solutions_seen = 0;
    longint cycle_count = 0;

    // floor(a*b / 2^sh), capped
    function automatic logic [63:0] mul_fx(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = (128'(a) * 128'(b)) >> sh;
        return (p > 128'(BIG_CAP)) ? BIG_CAP : p[63:0];
    endfunction

    // floor(a*2^sh / b), capped
    function automatic logic [63:0] div_fx(logic [63:0] a, int sh, logic [63:0] b,
                                           logic [63:0] cap);
        logic [127:0] q;
        if (b == 0) return (a != 0) ? cap : 64'd0;
        q = (128'(a) << sh) / 128'(b);
        return (q > 128'(cap)) ? cap : q[63:0];
    endfunction

    function automatic logic [63:0] denom_fx(logic [63:0] u);
        return mul_fx(u, u, FB) + mul_fx(64'(mob_ratio), mul_fx(ONE_FX - u, ONE_FX - u, FB),
                                         isbs_pkg::MOB_FRAC);
    endfunction

    function automatic longint residual(logic [63:0] u, t_cell c);
        logic [63:0] d, f, mag, bt;
        longint diff;
        d = denom_fx(u);
        f = (d == 0) ? 64'd0 : div_fx(mul_fx(u, u, FB), FB, d, ONE_FX);
        diff = longint'(f) - longint'(c.flux);
        mag = (diff < 0) ? -diff : diff;
        bt = mul_fx(64'(c.beta), mag, isbs_pkg::MOB_FRAC);
        return (diff < 0) ? longint'(u) - longint'(c.sat_old) - longint'(bt)
                          : longint'(u) - longint'(c.sat_old) + longint'(bt);
    endfunction

    function automatic t_sol solve_cell(t_cell c);
        logic [63:0] lo, hi, mid, root, d, n, g, slp, stp, mag;
        longint r, corr;
        t_sol s;
        lo = 0;
        hi = ONE_FX;
        for (int i = 0; i < NITER; i++) begin
            mid = (lo + hi) >> 1;
            r = residual(mid, c);
            if (r < 0) lo = mid;
            else if (r > 0) hi = mid;
        end
        root = (lo + hi) >> 1;
        r = residual(root, c);
        d = denom_fx(root);
        n = 2 * mul_fx(64'(mob_ratio), mul_fx(root, ONE_FX - root, FB), isbs_pkg::MOB_FRAC);
        g = (d == 0) ? 64'd0 : div_fx(div_fx(n, FB, d, BIG_CAP), FB, d, BIG_CAP);
        slp = ONE_FX + mul_fx(64'(c.beta), g, isbs_pkg::MOB_FRAC);
        mag = (r < 0) ? -r : r;
        stp = div_fx(mag, FB, slp, BIG_CAP);
        corr = (r < 0) ? longint'(root) + longint'(stp) : longint'(root) - longint'(stp);
        if (corr > 64'sd2147483647) corr = 64'sd2147483647;
        if (corr < -64'sd2147483648) corr = -64'sd2147483648;
        s.new_sat = corr[31:0];
        s.root = root[isbs_pkg::ROOT_W-1:0];
        return s;
    endfunction

    // driver: a transaction completes at the edge where start is high and busy low
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (start && !busy) begin
                solution_q.push_back(solve_cell({i_flux_target, i_step_ratio,
                                                 i_old_saturation}));
                cells_sent <= cells_sent + 1;
            end
            if (!(start && busy)) begin
                if (cell_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    t_cell c;
                    c = cell_q.pop_front();
                    start <= 1'b1;
                    i_flux_target <= c.flux;
                    i_step_ratio <= c.beta;
                    i_old_saturation <= c.sat_old;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            t_sol e;
            solutions_seen <= solutions_seen + 1;
            if (solution_q.size() == 0) begin
                $error("unexpected solution: new_saturation %0d", o_new_saturation);
                errors = errors + 1;
            end else begin
                e = solution_q.pop_front();
                if (o_new_saturation !== e.new_sat) begin
                    $error("new_saturation: expected %0d, got %0d", e.new_sat,
                           o_new_saturation);
                    errors = errors + 1;
                end
                if (o_bisection_root !== e.root) begin
                    $error("bisection_root: expected %0d, got %0d", e.root,
                           o_bisection_root);
                    errors = errors + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** implicit_saturation_bisection_solver: FAILED **");
            $finish;
        end
    end

    task automatic write_mobility(logic [isbs_pkg::MOB_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= isbs_pkg::APB_AW'(isbs_pkg::REG_MOBILITY) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mob_ratio = val;
    endtask

    task automatic drain();
        while (cell_q.size() > 0 || start || solution_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [30:0] rand_sat();
        case ($urandom_range(5))
            0: return 31'd0;
            1: return 31'(ONE_FX);
            2: return 31'($urandom);
            default: return 31'($urandom_range(32'(ONE_FX)));
        endcase
    endfunction

    function automatic logic [31:0] rand_beta();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(32'h0800_0000);
        endcase
    endfunction

    initial begin
        logic [isbs_pkg::MOB_W-1:0] mobs[6];
        int pcts[4];
        mobs = '{32'h0100_0000, 32'd1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0400_0000,
                 32'h0040_0000};
        mobs[3] = 32'd0;   // zero ratio: zero-denominator path
        pcts = '{0, 46, 13, 46};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, exact-zero residual, zero beta
        cell_q.push_back('{31'd0, 32'd0, 31'd0});
        cell_q.push_back('{31'(ONE_FX), 32'd0, 31'(ONE_FX)});
        cell_q.push_back('{31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF});
        cell_q.push_back('{31'd0, 32'hFFFF_FFFF, 31'(ONE_FX)});
        cell_q.push_back('{31'(ONE_FX), 32'hFFFF_FFFF, 31'd0});
        cell_q.push_back('{31'(ONE_FX >> 1), 32'h0100_0000, 31'(ONE_FX >> 1)});
        cell_q.push_back('{31'(ONE_FX >> 1), 32'd0, 31'(ONE_FX >> 1)});
        cell_q.push_back('{31'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAA});
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_mobility(mobs[ph]);
            idle_pct = pcts[ph % 4];
            repeat (325) cell_q.push_back('{rand_sat(), rand_beta(), rand_sat()});
            drain();
        end
        repeat (LATENCY + 50) @(posedge i_clk);

        $display("cells sent %0d, solutions checked %0d, six mobility ratios incl. 0 and max",
                 cells_sent, solutions_seen);
        if (errors == 0 && solution_q.size() == 0)
            $display("** implicit_saturation_bisection_solver: PASSED **");
        else
            $display("** implicit_saturation_bisection_solver: FAILED **");
        $finish;
    end
endmodule
